// ----- rtl/iae_pkg.sv -----
// Package for the integer ALU execute block.
// Holds opcode and result-kind codes, default sizes and the divider cell state type.
package iae_pkg;

    localparam int DefNumRegs  = 64;
    localparam int DefRobDepth = 64;
    localparam int WordW       = 32;

    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_ADD  = 4'd1,
        OP_MUL  = 4'd2,
        OP_SUB  = 4'd3,
        OP_DIV  = 4'd4,
        OP_LSH  = 4'd5,
        OP_RSH  = 4'd6,
        OP_AND  = 4'd7,
        OP_OR   = 4'd8,
        OP_XOR  = 4'd9,
        OP_LDC  = 4'd10,
        OP_HALT = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_REG   = 2'd1,
        KIND_HALT  = 2'd2
    } kind_t;

    // State that moves down the divider chain together with one instruction.
    typedef struct packed {
        kind_t              kind;
        logic               is_div;
        logic               neg;
        logic               dz;
        logic [WordW-1:0]   value;
        logic [WordW-1:0]   divisor;
        logic [WordW-1:0]   rem;
        logic [WordW-1:0]   work;
    } stage_t;

endpackage

// ----- rtl/iae_if.sv -----
// Handshake interfaces for issued instructions and writeback results.
// Depends on iae_pkg for the word width.
interface iae_issue_if
    import iae_pkg::*;
#(
    parameter int DW = 6,
    parameter int TW = 6
);
    logic                     valid;
    logic                     ready;
    logic [3:0]               mode;
    logic signed [WordW-1:0]  first_operand;
    logic signed [WordW-1:0]  second_operand;
    logic [DW-1:0]            dest_register;
    logic [TW-1:0]            rob_tag;

    modport source (output valid, mode, first_operand, second_operand, dest_register,
                    rob_tag, input ready);
    modport sink (input valid, mode, first_operand, second_operand, dest_register,
                  rob_tag, output ready);
endinterface

interface iae_wb_if
    import iae_pkg::*;
#(
    parameter int DW = 6,
    parameter int TW = 6
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic signed [DW:0]       dest_out;
    logic signed [TW:0]       tag_out;
    logic signed [WordW-1:0]  value;

    modport source (output valid, kind, dest_out, tag_out, value, input ready);
    modport sink (input valid, kind, dest_out, tag_out, value, output ready);
endinterface

// ----- rtl/iae_div_cell.sv -----
// One cell of the divider chain: a restoring divide step on the carried state.
// Depends on iae_pkg for stage_t.
module iae_div_cell
    import iae_pkg::*;
#(
    parameter int DW = 6,
    parameter int TW = 6
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid,
    input  stage_t        st,
    input  logic [DW-1:0] dest,
    input  logic [TW-1:0] tag,
    output logic          valid_q,
    output stage_t        st_q,
    output logic [DW-1:0] dest_q,
    output logic [TW-1:0] tag_q
);
    logic              valid_reg;
    stage_t            st_reg;
    stage_t            st_next;
    logic [DW-1:0]     dest_reg;
    logic [TW-1:0]     tag_reg;
    logic [WordW:0]    trial;
    logic [WordW-1:0]  shifted;

    // Shift one dividend bit into the remainder and try the subtraction.
    always_comb
    begin
        st_next = st;
        shifted = {st.rem[WordW-2:0], st.work[WordW-1]};
        trial   = {st.rem[WordW-1], shifted} - {1'b0, st.divisor};
        if (st.is_div)
        begin
            if (!trial[WordW])
            begin
                st_next.rem  = trial[WordW-1:0];
                st_next.work = {st.work[WordW-2:0], 1'b1};
            end
            else
            begin
                st_next.rem  = shifted;
                st_next.work = {st.work[WordW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            dest_reg <= dest;
            tag_reg  <= tag;
        end
    end

    assign valid_q = valid_reg;
    assign st_q    = st_reg;
    assign dest_q  = dest_reg;
    assign tag_q   = tag_reg;
endmodule

// ----- rtl/integer_alu_execute_top.sv -----
// Top level of the integer ALU execute block.
// Depends on iae_pkg, the interfaces in iae_if and the iae_div_cell chain.

// The block takes one issued instruction per clock cycle while not stalled and returns exactly
// one writeback result per instruction, in issue order. Every instruction goes through the same
// pipeline: an entry stage that decodes the opcode and computes every operation except divide
// (the multiply completes there), then a chain of 32 divider cells that each resolve one
// quotient bit, then an output register that fixes the quotient sign and builds the result.
// The sustained rate is one instruction per cycle while the output is not stalled. The whole
// pipeline advances together, so the issue side is ready exactly when the output register is
// empty or is being taken. A divide by zero returns 0x7FFFFFFF, and the most negative value
// divided by minus one wraps to itself.
module integer_alu_execute_top
    import iae_pkg::*;
#(
    parameter int NUM_REGS  = DefNumRegs,
    parameter int ROB_DEPTH = DefRobDepth,
    localparam int DW = $clog2(NUM_REGS),
    localparam int TW = $clog2(ROB_DEPTH)
)(
    input logic              clk,
    input logic              rst_n,
    iae_issue_if.sink        issue,
    iae_wb_if.source         wb
);
    localparam int Cells = WordW;

    logic                    en;
    logic [WordW-1:0]        a;
    logic [WordW-1:0]        b;
    logic [4:0]              sh;
    stage_t                  entry_next;
    stage_t                  entry_reg;
    logic                    entry_valid_reg;
    logic [DW-1:0]           entry_dest_reg;
    logic [TW-1:0]           entry_tag_reg;

    logic                    c_valid [Cells+1];
    stage_t                  c_st    [Cells+1];
    logic [DW-1:0]           c_dest  [Cells+1];
    logic [TW-1:0]           c_tag   [Cells+1];

    logic                    out_valid_reg;
    logic [1:0]              kind_reg;
    logic signed [DW:0]      dest_reg;
    logic signed [TW:0]      tag_reg;
    logic [WordW-1:0]        value_reg;
    stage_t                  fin;
    logic [1:0]              kind_next;
    logic signed [DW:0]      dest_next;
    logic signed [TW:0]      tag_next;
    logic [WordW-1:0]        value_next;

    // The pipeline moves as a whole unless a finished result is waiting.
    assign en          = !out_valid_reg || wb.ready;
    assign issue.ready = en;

    assign a  = issue.first_operand;
    assign b  = issue.second_operand;
    assign sh = b[4:0];

    // Entry decode: every operation but divide is finished here.
    always_comb
    begin
        entry_next         = '0;
        entry_next.kind    = KIND_REG;
        entry_next.value   = '1;
        entry_next.neg     = a[WordW-1] ^ b[WordW-1];
        entry_next.dz      = (b == '0);
        entry_next.divisor = b[WordW-1] ? (~b + 1'b1) : b;
        entry_next.work    = a[WordW-1] ? (~a + 1'b1) : a;
        unique case (issue.mode)
            OP_ADD:  entry_next.value = a + b;
            OP_MUL:  entry_next.value = a * b;
            OP_SUB:  entry_next.value = a - b;
            OP_DIV:  entry_next.is_div = 1'b1;
            OP_LSH:  entry_next.value = a << sh;
            OP_RSH:  entry_next.value = $signed(a) >>> sh;
            OP_AND:  entry_next.value = a & b;
            OP_OR:   entry_next.value = a | b;
            OP_XOR:  entry_next.value = a ^ b;
            OP_LDC:  entry_next.value = b;
            OP_HALT: entry_next.kind  = KIND_HALT;
            default: entry_next.kind  = KIND_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg      <= entry_next;
            entry_dest_reg <= issue.dest_register;
            entry_tag_reg  <= issue.rob_tag;
        end
    end

    assign c_valid[0] = entry_valid_reg;
    assign c_st[0]    = entry_reg;
    assign c_dest[0]  = entry_dest_reg;
    assign c_tag[0]   = entry_tag_reg;

    // One quotient bit per cell, most significant first.
    for (genvar i = 0; i < Cells; i++)
    begin : g_cell
        iae_div_cell #(
            .DW(DW),
            .TW(TW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid   (c_valid[i]),
            .st      (c_st[i]),
            .dest    (c_dest[i]),
            .tag     (c_tag[i]),
            .valid_q (c_valid[i+1]),
            .st_q    (c_st[i+1]),
            .dest_q  (c_dest[i+1]),
            .tag_q   (c_tag[i+1])
        );
    end

    // Result assembly: quotient sign and divide-by-zero handling, then field encoding.
    always_comb
    begin
        fin        = c_st[Cells];
        kind_next  = fin.kind;
        dest_next  = '1;
        tag_next   = '1;
        value_next = '1;
        unique case (fin.kind)
            KIND_REG:
            begin
                dest_next = {1'b0, c_dest[Cells]};
                tag_next  = {1'b0, c_tag[Cells]};
                if (!fin.is_div)
                    value_next = fin.value;
                else if (fin.dz)
                    value_next = {1'b0, {(WordW-1){1'b1}}};
                else if (fin.neg)
                    value_next = ~fin.work + 1'b1;
                else
                    value_next = fin.work;
            end
            KIND_HALT:
            begin
                tag_next = {1'b0, c_tag[Cells]};
            end
            default:
            begin
                kind_next = KIND_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid[Cells];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg  <= kind_next;
            dest_reg  <= dest_next;
            tag_reg   <= tag_next;
            value_reg <= value_next;
        end
    end

    assign wb.valid    = out_valid_reg;
    assign wb.kind     = kind_reg;
    assign wb.dest_out = dest_reg;
    assign wb.tag_out  = tag_reg;
    assign wb.value    = value_reg;

    // An empty result carries all-ones in its register, tag and value fields.
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (wb.valid && wb.kind == KIND_EMPTY) |-> (&wb.dest_out && &wb.tag_out && &wb.value))
        else $error("empty result with non-default fields");

    // A halt marker never names a destination register.
    a_halt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (wb.valid && wb.kind == KIND_HALT) |-> (&wb.dest_out && &wb.value))
        else $error("halt marker with a destination or value");

    // A result held back must not be overwritten by the chain behind it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (wb.valid && !wb.ready) |=> (wb.valid && $stable(wb.value) && $stable(wb.kind)))
        else $error("stalled result changed");

    // An instruction at the chain end always reaches the output on an advancing cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && c_valid[Cells]) |=> wb.valid)
        else $error("result lost at the output register");
endmodule
